/* hdl/g2bpp_pkg.sv */
// ----------------------------------------------------------------------------
// g2bpp_pkg
// Shared types, constants and the palette function for the 2bpp glyph
// expander.
// ----------------------------------------------------------------------------
package g2bpp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_FORE_COLOUR = 2'd0;
    localparam logic [1:0] CFG_BACK_COLOUR = 2'd1;
    localparam logic [1:0] CFG_DRAW_MODE   = 2'd2;

    // Draw mode bit positions
    localparam int DM_INVERSE = 0;
    localparam int DM_FILL    = 1;
    localparam int DM_OUTLINE = 2;

    // Pixels in one source byte, and reset colours
    localparam logic [2:0] PIX_PER_BYTE  = 3'd4;
    localparam logic [7:0] FORE_RESET    = 8'hff;
    localparam logic [7:0] BACK_RESET    = 8'h00;
    localparam logic [2:0] MODE_RESET    = 3'd0;

    typedef struct packed {
        logic [7:0] src_byte;
        logic [2:0] pixel_count;
        logic       row_start;
        logic       row_end;
        logic [1:0] byte_offset;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic [3:0]  byte_enable;
        logic        row_last;
    } out_item_t;

    // Row accumulator state
    typedef struct packed {
        logic [1:0]       lane;
        logic [3:0][7:0]  word;
        logic [3:0]       enable;
    } row_state_t;

    // Up to two words produced by one source byte
    typedef struct packed {
        out_item_t  first;
        out_item_t  second;
        logic [1:0] count;
    } pack_res_t;

    // Map a 2-bit index through the palette set by the draw mode
    function automatic logic [7:0] palette_entry(
        input logic [1:0] idx,
        input logic [7:0] fore,
        input logic [7:0] back,
        input logic [2:0] mode
    );
        logic [7:0] ink;
        logic [7:0] bg;
        logic [7:0] val;
        ink = mode[DM_INVERSE] ? back : fore;
        bg  = mode[DM_INVERSE] ? fore : back;
        unique case (idx)
            2'd0:    val = mode[DM_FILL] ? bg : 8'h00;
            2'd1:    val = (mode[DM_FILL] || mode[DM_OUTLINE]) ? bg : 8'h00;
            default: val = ink;
        endcase
        return val;
    endfunction

endpackage

/* hdl/glyph_2bpp_expand_masked_unit.sv */
// ----------------------------------------------------------------------------
// glyph_2bpp_expand_masked_unit
// Expands 2bpp font bytes into byte-masked 32-bit pixel words.
// ----------------------------------------------------------------------------
// One source byte is taken per clock while the result side takes every word:
// the byte is expanded through the palette and packed in the same cycle into
// a two-entry result buffer, so a word appears on the result channel in the
// cycle after its byte is accepted. A byte is taken only when both buffer
// entries will be free, since it may complete a word and also flush the row
// tail; a byte that yields two words therefore holds the input while the
// second word drains. Configuration writes take effect on the next accepted
// byte and are meant to be made while the unit is idle.
module glyph_2bpp_expand_masked_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  g2bpp_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output g2bpp_pkg::out_item_t m_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_wdata
);

    logic [7:0]            fore_reg;
    logic [7:0]            back_reg;
    logic [2:0]            mode_reg;
    g2bpp_pkg::row_state_t row_reg;
    g2bpp_pkg::row_state_t row_next;
    g2bpp_pkg::pack_res_t  res;
    g2bpp_pkg::out_item_t  slot_reg [2];
    logic [1:0]            count_reg;
    logic                  s_fire;
    logic                  m_fire;

    assign m_valid = (count_reg != 2'd0);
    assign m_item  = slot_reg[0];
    assign m_fire  = m_valid && m_ready;
    assign s_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);
    assign s_fire  = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fore_reg <= g2bpp_pkg::FORE_RESET;
            back_reg <= g2bpp_pkg::BACK_RESET;
            mode_reg <= g2bpp_pkg::MODE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                g2bpp_pkg::CFG_FORE_COLOUR: fore_reg <= cfg_wdata;
                g2bpp_pkg::CFG_BACK_COLOUR: back_reg <= cfg_wdata;
                g2bpp_pkg::CFG_DRAW_MODE:   mode_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    g2bpp_pack u_pack (
        .cur         (row_reg),
        .item        (s_item),
        .fore_colour (fore_reg),
        .back_colour (back_reg),
        .draw_mode   (mode_reg),
        .res         (res),
        .nxt         (row_next)
    );

    // Advance the row accumulator on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else if (s_fire) begin
            row_reg <= row_next;
        end
    end

    // Result buffer: load on input transfer, shift down on output transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (s_fire) begin
            count_reg <= res.count;
        end else if (m_fire) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            slot_reg[0] <= res.first;
            slot_reg[1] <= res.second;
        end else if (m_fire) begin
            slot_reg[0] <= slot_reg[1];
        end
    end

    // Checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_room_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> (count_reg == 2'd0) || (count_reg == 2'd1 && m_fire))
        else $error("input accepted without two free result entries");

    a_second_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> slot_reg[1].row_last)
        else $error("second buffered word is not the row tail");

    a_row_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_item.row_end) |=> (row_reg == '0))
        else $error("accumulator not cleared after row end");

endmodule

/* hdl/g2bpp_pack.sv */
// ----------------------------------------------------------------------------
// g2bpp_pack
// Expands one source byte into the row accumulator and works out the words
// that it completes or flushes, with the accumulator state that follows.
// ----------------------------------------------------------------------------
module g2bpp_pack (
    input  g2bpp_pkg::row_state_t cur,
    input  g2bpp_pkg::in_item_t   item,
    input  logic [7:0]            fore_colour,
    input  logic [7:0]            back_colour,
    input  logic [2:0]            draw_mode,
    output g2bpp_pkg::pack_res_t  res,
    output g2bpp_pkg::row_state_t nxt
);

    logic [1:0]      base_lane;
    logic [3:0][7:0] w1;
    logic [3:0][7:0] w2;
    logic [3:0]      e1;
    logic [3:0]      e2;
    logic [2:0]      used;
    logic [2:0]      end_pos;
    logic [2:0]      pos;
    logic [7:0]      val;
    logic            word_done;
    logic            flush;

    // Start point: fresh row or carry on from the accumulator
    always_comb begin
        base_lane = item.row_start ? item.byte_offset : cur.lane;
        used      = (item.pixel_count > g2bpp_pkg::PIX_PER_BYTE) ?
                    g2bpp_pkg::PIX_PER_BYTE : item.pixel_count;
        end_pos   = {1'b0, base_lane} + used;
        word_done = end_pos[2];
        flush     = item.row_end && (end_pos[1:0] != 2'd0);
    end

    // Drop each pixel into the current word or the one after it
    always_comb begin
        w1  = item.row_start ? '0 : cur.word;
        e1  = item.row_start ? '0 : cur.enable;
        w2  = '0;
        e2  = '0;
        pos = '0;
        val = '0;
        for (int p = 0; p < 4; p++) begin
            pos = {1'b0, base_lane} + 3'(p);
            val = g2bpp_pkg::palette_entry(item.src_byte[(3 - p) * 2 +: 2],
                                           fore_colour, back_colour, draw_mode);
            if (3'(p) < used) begin
                if (!pos[2]) begin
                    w1[pos[1:0]] = val;
                    e1[pos[1:0]] = (val != 8'h00);
                end else begin
                    w2[pos[1:0]] = val;
                    e2[pos[1:0]] = (val != 8'h00);
                end
            end
        end
    end

    // Select result words and the following state
    always_comb begin
        res.first.pixel_word  = w1;
        res.first.byte_enable = e1;
        res.second.pixel_word  = w2;
        res.second.byte_enable = e2;
        res.second.row_last    = 1'b1;
        if (word_done) begin
            res.first.row_last = item.row_end && !flush;
            res.count          = flush ? 2'd2 : 2'd1;
        end else begin
            res.first.row_last = 1'b1;
            res.count          = flush ? 2'd1 : 2'd0;
        end

        if (item.row_end) begin
            nxt = '0;
        end else begin
            nxt.lane   = end_pos[1:0];
            nxt.word   = word_done ? w2 : w1;
            nxt.enable = word_done ? e2 : e1;
        end
    end

endmodule
